// ===== rtl/core/rgb_to_hsl_converter_macros.svh =====
// assertion macros for the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RHSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RHSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rhsl_pkg.sv =====
// shared types and constants of the rgb to hsl converter
package rhsl_pkg;

    localparam int HUE_Q_W   = 12;
    localparam int DIV_STEPS = 16;

    localparam logic [14:0] HUE_OFS_RED   = 15'd0;
    localparam logic [14:0] HUE_OFS_GREEN = 15'd7680;
    localparam logic [14:0] HUE_OFS_BLUE  = 15'd15360;
    localparam logic [14:0] HUE_TURN      = 15'd23040;
    localparam logic [15:0] SAT_ONE       = 16'd32768;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [19:0] hue_num;
        logic [7:0]  hue_den;
        logic [22:0] sat_num;
        logic [7:0]  sat_den;
        logic        neg;
        t_sector     sector;
        logic        achrom;
        logic [8:0]  sum;
    } t_front;

    typedef struct packed {
        logic [15:0] hue_q;
        logic [15:0] sat_q;
        logic        neg;
        t_sector     sector;
        logic        achrom;
        logic [8:0]  sum;
    } t_div_out;

endpackage

// ===== rtl/core/rhsl_front.sv =====
// input stage: max, min, sector choice and divider operands
module rhsl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    output logic              o_valid,
    output rhsl_pkg::t_front  o_data
);
    import rhsl_pkg::*;

    logic       r_valid;
    t_front     r_data;
    t_front     n_data;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chroma;
    logic [8:0] diff;
    logic [7:0] mag;
    logic [8:0] sum;
    logic [8:0] den_full;
    t_sector    sector;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            sector = SEC_RED;
            hi     = i_red;
            diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= i_blue) begin
            sector = SEC_GREEN;
            hi     = i_green;
            diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            sector = SEC_BLUE;
            hi     = i_blue;
            diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            lo = i_red;
        end else if (i_green <= i_blue) begin
            lo = i_green;
        end else begin
            lo = i_blue;
        end
        chroma   = hi - lo;
        mag      = diff[8] ? 8'(-diff) : diff[7:0];
        sum      = {1'b0, hi} + {1'b0, lo};
        den_full = (sum >= 9'd255) ? (9'd510 - sum) : sum;

        n_data.hue_num = {mag, 12'b0} - {4'b0, mag, 8'b0};
        n_data.hue_den = chroma;
        n_data.sat_num = {chroma, 15'b0};
        n_data.sat_den = den_full[7:0];
        n_data.neg     = diff[8];
        n_data.sector  = sector;
        n_data.achrom  = (chroma == 8'd0);
        n_data.sum     = sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rhsl_div.sv =====
// pipelined restoring dividers for hue and saturation, one quotient bit per stage
module rhsl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rhsl_pkg::t_front    i_data,
    output logic                o_valid,
    output rhsl_pkg::t_div_out  o_data
);
    import rhsl_pkg::*;

    typedef struct packed {
        logic [7:0]  rem;
        logic [15:0] lo;
        logic [15:0] q;
    } t_lane;

    typedef struct packed {
        t_lane      hue;
        t_lane      sat;
        logic [7:0] hue_den;
        logic [7:0] sat_den;
        logic       neg;
        t_sector    sector;
        logic       achrom;
        logic [8:0] sum;
    } t_stage;

    function automatic t_lane div_step(t_lane a, logic [7:0] den);
        t_lane      res;
        logic [8:0] t;
        logic       ge;
        t       = {a.rem, a.lo[15]};
        ge      = (t >= {1'b0, den});
        res.rem = ge ? 8'(t - {1'b0, den}) : t[7:0];
        res.lo  = {a.lo[14:0], 1'b0};
        res.q   = {a.q[14:0], ge};
        return res;
    endfunction

    logic   r_valid [DIV_STEPS];
    t_stage r_stg   [DIV_STEPS];
    t_stage n_stg   [DIV_STEPS];
    t_stage first;

    always_comb begin
        first.hue.rem = {4'b0, i_data.hue_num[19:16]};
        first.hue.lo  = i_data.hue_num[15:0];
        first.hue.q   = '0;
        first.sat.rem = {1'b0, i_data.sat_num[22:16]};
        first.sat.lo  = i_data.sat_num[15:0];
        first.sat.q   = '0;
        first.hue_den = i_data.hue_den;
        first.sat_den = i_data.sat_den;
        first.neg     = i_data.neg;
        first.sector  = i_data.sector;
        first.achrom  = i_data.achrom;
        first.sum     = i_data.sum;
    end

    always_comb begin
        n_stg[0] = first;
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_stg[k] = r_stg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_stg[k].hue = div_step(n_stg[k].hue, n_stg[k].hue_den);
            n_stg[k].sat = div_step(n_stg[k].sat, n_stg[k].sat_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid       = r_valid[DIV_STEPS-1];
    assign o_data.hue_q  = r_stg[DIV_STEPS-1].hue.q;
    assign o_data.sat_q  = r_stg[DIV_STEPS-1].sat.q;
    assign o_data.neg    = r_stg[DIV_STEPS-1].neg;
    assign o_data.sector = r_stg[DIV_STEPS-1].sector;
    assign o_data.achrom = r_stg[DIV_STEPS-1].achrom;
    assign o_data.sum    = r_stg[DIV_STEPS-1].sum;

endmodule

// ===== rtl/core/rhsl_back.sv =====
// hue sector offset and wrap, output register with skid stage
module rhsl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhsl_pkg::t_div_out  i_data,
    input  logic                i_out_stall,
    output logic                o_en,
    output logic                o_out_valid,
    output logic [14:0]         o_hue,
    output logic [15:0]         o_saturation,
    output logic [8:0]          o_lightness_twice,
    output logic                o_achromatic
);
    import rhsl_pkg::*;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] sat;
        logic [8:0]  lt;
        logic        achrom;
    } t_result;

    t_result             res;
    t_result             r_out;
    t_result             r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                en;
    logic                take;
    logic                in_item;
    logic [14:0]         offset;
    logic [14:0]         base;
    logic [HUE_Q_W-1:0]  q;

    always_comb begin
        case (i_data.sector)
            SEC_RED:   offset = HUE_OFS_RED;
            SEC_GREEN: offset = HUE_OFS_GREEN;
            SEC_BLUE:  offset = HUE_OFS_BLUE;
            default:   offset = HUE_OFS_RED;
        endcase
        q    = i_data.hue_q[HUE_Q_W-1:0];
        base = (i_data.sector == SEC_RED) ? HUE_TURN : offset;
        if (i_data.achrom) begin
            res.hue = '0;
            res.sat = '0;
        end else begin
            res.hue = i_data.neg ? (base - 15'(q)) : (offset + 15'(q));
            res.sat = i_data.sat_q;
        end
        res.lt     = i_data.sum;
        res.achrom = i_data.achrom;
    end

    assign en      = !r_skid_valid;
    assign take    = r_out_valid && !i_out_stall;
    assign in_item = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid || in_item;
            r_skid_valid <= 1'b0;
        end else if (in_item) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (r_out_valid && !take && in_item) begin
            r_skid <= res;
        end
    end

    assign o_en              = en;
    assign o_out_valid       = r_out_valid;
    assign o_hue             = r_out.hue;
    assign o_saturation      = r_out.sat;
    assign o_lightness_twice = r_out.lt;
    assign o_achromatic      = r_out.achrom;

endmodule

// ===== rtl/core/rgb_to_hsl_converter.sv =====
// top level of the rgb to hsl converter
// an accepted item passes the front register and the 16 divider stages on to the output register
// throughput: one item per cycle while input stall is low; both dividers take one quotient bit per stage over 16 stages
// a result waiting at the output is covered by one skid entry before input stall rises
// reset (synchronous, active low) clears all valid bits; data registers are not reset
module rgb_to_hsl_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [14:0] o_hue,
    output logic [15:0] o_saturation,
    output logic [8:0]  o_lightness_twice,
    output logic        o_achromatic
);
    import rhsl_pkg::*;

    `include "rgb_to_hsl_converter_macros.svh"

    logic     en;
    logic     front_valid;
    t_front   front_data;
    logic     div_valid;
    t_div_out div_data;

    rhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (front_valid),
        .o_data  (front_data)
    );

    rhsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    rhsl_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (div_valid),
        .i_data            (div_data),
        .i_out_stall       (i_out_stall),
        .o_en              (en),
        .o_out_valid       (o_out_valid),
        .o_hue             (o_hue),
        .o_saturation      (o_saturation),
        .o_lightness_twice (o_lightness_twice),
        .o_achromatic      (o_achromatic)
    );

    assign o_in_stall = !en;

    `RHSL_ASSERT_NOW(a_achrom_zero, o_out_valid && o_achromatic, o_hue == 15'd0 && o_saturation == 16'd0, "achromatic item with nonzero hue or saturation")
    `RHSL_ASSERT_NOW(a_hue_range, o_out_valid, o_hue < HUE_TURN, "hue out of range")
    `RHSL_ASSERT_NOW(a_sat_range, o_out_valid && !o_achromatic, o_saturation != 16'd0 && o_saturation <= SAT_ONE, "saturation out of range")
    `RHSL_ASSERT_NOW(a_skid_fill, $rose(o_in_stall), $past(o_out_valid && i_out_stall), "skid filled without output stall")

endmodule
